@@ hw/rtl/swarq_pkg.sv @@
// Shared types and constants of the stop-and-wait ARQ sender.
`default_nettype none

package swarq_pkg;

  localparam int QUEUE_DEPTH   = 16;
  localparam int PAYLOAD_BYTES = 20;

  localparam logic [15:0] TIMEOUT_RESET = 16'd20;
  localparam logic [31:0] DATA_ACK_FIELD = 32'hFFFF_FFFF;

  localparam logic [1:0] REQ_MSG_BYTE = 2'd0;
  localparam logic [1:0] REQ_ACK      = 2'd1;
  localparam logic [1:0] REQ_TICK     = 2'd2;

  localparam logic KIND_PACKET = 1'b0;
  localparam logic KIND_DROP   = 1'b1;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  msg_byte;
    logic [31:0] ack_seq_field;
    logic [31:0] ack_number;
    logic [31:0] ack_checksum;
  } req_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] pkt_seq;
    logic [31:0] pkt_checksum;
    logic [7:0]  pkt_byte;
    logic [4:0]  byte_pos;
    logic        last;
  } rsp_t;

  typedef struct packed {
    logic [31:0] seq;
    logic [31:0] sum;
  } hdr_t;

endpackage

`default_nettype wire

@@ hw/rtl/swarq_mem.sv @@
// Queue storage: payload byte memory and per-packet header memory.
`default_nettype none

module swarq_mem #(
  parameter int QUEUE_DEPTH   = swarq_pkg::QUEUE_DEPTH,
  parameter int PAYLOAD_BYTES = swarq_pkg::PAYLOAD_BYTES,
  localparam int PL_DEPTH     = QUEUE_DEPTH * PAYLOAD_BYTES,
  localparam int ADDR_W       = (PL_DEPTH > 1) ? $clog2(PL_DEPTH) : 1,
  localparam int PTR_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
  input  wire                    clk,
  input  wire                    pl_wr_en,
  input  wire [ADDR_W-1:0]       pl_wr_addr,
  input  wire [7:0]              pl_wr_data,
  input  wire                    hdr_wr_en,
  input  wire [PTR_W-1:0]        hdr_wr_addr,
  input  wire swarq_pkg::hdr_t   hdr_wr_data,
  input  wire                    rd_en,
  input  wire [ADDR_W-1:0]       pl_rd_addr,
  input  wire [PTR_W-1:0]        hdr_rd_addr,
  output logic [7:0]             pl_rd_data,
  output swarq_pkg::hdr_t        hdr_rd_data
);

  logic [7:0]      pl_mem  [PL_DEPTH];
  swarq_pkg::hdr_t hdr_mem [QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (pl_wr_en) begin
      pl_mem[pl_wr_addr] <= pl_wr_data;
    end
    if (rd_en) begin
      pl_rd_data <= pl_mem[pl_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (hdr_wr_en) begin
      hdr_mem[hdr_wr_addr] <= hdr_wr_data;
    end
    if (rd_en) begin
      hdr_rd_data <= hdr_mem[hdr_rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/stop_and_wait_arq_sender.sv @@
// Stop-and-wait ARQ sender: message assembly, packet queue, transmit and retry control.
//
// Requests enter on req_valid/req_ready with a req_t payload: a message byte, an
// arriving ACK or a timer tick. Results leave on rsp_valid/rsp_ready as rsp_t:
// either one byte of an outgoing packet or a single drop report for a message
// that found the queue full. The timeout register is written on cfg_valid/cfg_data
// and is always ready; it takes effect at the next timer load.
// Message bytes are taken one per cycle while the sender is in ST_IDLE and written
// straight into the payload memory, unless the queue was full at the first byte. A request
// that starts a transmission (a completed message while idle, a matching ACK with
// packets left, or a timer expiry) is followed by a burst of PAYLOAD_BYTES results;
// each byte takes a memory read and then a load of the output register, and no request
// is taken during the burst, nor until a drop report has been loaded.
// When the receiver stalls, the output register holds its result and the burst
// pauses on the memory read data; requests are still taken while the last
// result waits. Reset empties the queue, clears sequence numbers and timer and
// sets the timeout to 20 ticks; the memories need no clearing.
`default_nettype none

module stop_and_wait_arq_sender #(
  parameter int QUEUE_DEPTH   = swarq_pkg::QUEUE_DEPTH,
  parameter int PAYLOAD_BYTES = swarq_pkg::PAYLOAD_BYTES
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              req_valid,
  output logic             req_ready,
  input  wire swarq_pkg::req_t req_data,
  output logic             rsp_valid,
  input  wire              rsp_ready,
  output swarq_pkg::rsp_t  rsp_data,
  input  wire              cfg_valid,
  output logic             cfg_ready,
  input  wire [15:0]       cfg_data
);

  localparam int PL_DEPTH = QUEUE_DEPTH * PAYLOAD_BYTES;
  localparam int ADDR_W   = (PL_DEPTH > 1) ? $clog2(PL_DEPTH) : 1;
  localparam int PTR_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int POS_W    = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_DROP
  } state_t;

  state_t             state;
  logic               waiting;
  logic [31:0]        next_seq;
  logic [31:0]        expected_ack;
  logic [15:0]        ticks_left;
  logic [15:0]        timeout_ticks;
  logic [POS_W-1:0]   asm_pos;
  logic [31:0]        asm_sum;
  logic               asm_blocked;
  logic [PTR_W-1:0]   head;
  logic [PTR_W-1:0]   tail;
  logic [CNT_W-1:0]   count;
  logic [POS_W-1:0]   send_pos;

  logic               accept;
  logic               first_byte;
  logic               blocked_now;
  logic [31:0]        sum_now;
  logic               msg_done;
  logic               ack_ok;
  logic [CNT_W-1:0]   count_after_pop;
  logic [PTR_W-1:0]   head_inc;
  logic [PTR_W-1:0]   tail_inc;
  logic               send_last;
  logic               out_free;

  logic               pl_wr_en;
  logic [ADDR_W-1:0]  pl_wr_addr;
  logic               hdr_wr_en;
  swarq_pkg::hdr_t    hdr_wr_data;
  logic               rd_en;
  logic [ADDR_W-1:0]  pl_rd_addr;
  logic [7:0]         pl_rd_data;
  swarq_pkg::hdr_t    hdr_rd_data;

  assign req_ready = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = req_valid && req_ready;
  assign out_free  = !rsp_valid || rsp_ready;

  assign first_byte  = (asm_pos == '0);
  assign blocked_now = first_byte ? (count >= CNT_W'(QUEUE_DEPTH)) : asm_blocked;
  assign sum_now     = (first_byte ? 32'd0 : asm_sum) + 32'(req_data.msg_byte);
  assign msg_done    = (asm_pos == POS_W'(PAYLOAD_BYTES - 1));

  assign ack_ok = waiting
               && (req_data.ack_checksum == req_data.ack_seq_field + req_data.ack_number)
               && (req_data.ack_number == expected_ack);

  assign count_after_pop = count - CNT_W'(count != '0);
  assign head_inc  = (head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head + PTR_W'(1);
  assign tail_inc  = (tail == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail + PTR_W'(1);
  assign send_last = (send_pos == POS_W'(PAYLOAD_BYTES - 1));

  assign pl_wr_en   = accept && (req_data.req_type == swarq_pkg::REQ_MSG_BYTE) && !blocked_now;
  assign pl_wr_addr = ADDR_W'(tail) * ADDR_W'(PAYLOAD_BYTES) + ADDR_W'(asm_pos);
  assign hdr_wr_en  = pl_wr_en && msg_done;
  assign hdr_wr_data.seq = next_seq;
  assign hdr_wr_data.sum = next_seq + swarq_pkg::DATA_ACK_FIELD + sum_now;

  assign rd_en      = (state == ST_READ);
  assign pl_rd_addr = ADDR_W'(head) * ADDR_W'(PAYLOAD_BYTES) + ADDR_W'(send_pos);

  swarq_mem #(
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_mem (
    .clk         (clk),
    .pl_wr_en    (pl_wr_en),
    .pl_wr_addr  (pl_wr_addr),
    .pl_wr_data  (req_data.msg_byte),
    .hdr_wr_en   (hdr_wr_en),
    .hdr_wr_addr (tail),
    .hdr_wr_data (hdr_wr_data),
    .rd_en       (rd_en),
    .pl_rd_addr  (pl_rd_addr),
    .hdr_rd_addr (head),
    .pl_rd_data  (pl_rd_data),
    .hdr_rd_data (hdr_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      waiting       <= 1'b0;
      next_seq      <= '0;
      expected_ack  <= '0;
      ticks_left    <= '0;
      timeout_ticks <= swarq_pkg::TIMEOUT_RESET;
      asm_pos       <= '0;
      asm_sum       <= '0;
      asm_blocked   <= 1'b0;
      head          <= '0;
      tail          <= '0;
      count         <= '0;
      send_pos      <= '0;
      rsp_valid     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        timeout_ticks <= cfg_data;
      end
      if (rsp_valid && rsp_ready && state != ST_LOAD && state != ST_DROP) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req_valid) begin
            case (req_data.req_type)
              swarq_pkg::REQ_MSG_BYTE: begin
                asm_sum     <= sum_now;
                asm_blocked <= blocked_now && !msg_done;
                if (msg_done) begin
                  asm_pos <= '0;
                  if (blocked_now) begin
                    state <= ST_DROP;
                  end else begin
                    tail     <= tail_inc;
                    count    <= count + CNT_W'(1);
                    next_seq <= next_seq + 32'd1;
                    if (!waiting) begin
                      waiting    <= 1'b1;
                      ticks_left <= timeout_ticks;
                      send_pos   <= '0;
                      state      <= ST_READ;
                    end
                  end
                end else begin
                  asm_pos <= asm_pos + POS_W'(1);
                end
              end
              swarq_pkg::REQ_ACK: begin
                if (ack_ok) begin
                  waiting      <= (count_after_pop != '0);
                  expected_ack <= expected_ack + 32'd1;
                  if (count != '0) begin
                    head  <= head_inc;
                    count <= count_after_pop;
                  end
                  if (count_after_pop != '0) begin
                    ticks_left <= timeout_ticks;
                    send_pos   <= '0;
                    state      <= ST_READ;
                  end
                end
              end
              swarq_pkg::REQ_TICK: begin
                if (waiting) begin
                  if (ticks_left > 16'd1) begin
                    ticks_left <= ticks_left - 16'd1;
                  end else if (count == '0) begin
                    waiting <= 1'b0;
                  end else begin
                    ticks_left <= timeout_ticks;
                    send_pos   <= '0;
                    state      <= ST_READ;
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_READ: begin
          state <= ST_LOAD;
        end
        ST_LOAD: begin
          if (out_free) begin
            rsp_valid             <= 1'b1;
            rsp_data.kind         <= swarq_pkg::KIND_PACKET;
            rsp_data.pkt_seq      <= hdr_rd_data.seq;
            rsp_data.pkt_checksum <= hdr_rd_data.sum;
            rsp_data.pkt_byte     <= pl_rd_data;
            rsp_data.byte_pos     <= 5'(send_pos);
            rsp_data.last         <= send_last;
            if (send_last) begin
              state <= ST_IDLE;
            end else begin
              send_pos <= send_pos + POS_W'(1);
              state    <= ST_READ;
            end
          end
        end
        ST_DROP: begin
          if (out_free) begin
            rsp_valid             <= 1'b1;
            rsp_data.kind         <= swarq_pkg::KIND_DROP;
            rsp_data.pkt_seq      <= '0;
            rsp_data.pkt_checksum <= '0;
            rsp_data.pkt_byte     <= '0;
            rsp_data.byte_pos     <= '0;
            rsp_data.last         <= 1'b1;
            state                 <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("Queue count exceeds the queue depth.");

  a_wait_has_packet: assert property (@(posedge clk) disable iff (rst)
    waiting |-> (count != '0))
    else $error("Waiting for an acknowledgement with an empty queue.");

  a_send_has_packet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ || state == ST_LOAD) |-> (waiting && count != '0))
    else $error("Packet transmission without a queued packet.");

  a_timer_load: assert property (@(posedge clk) disable iff (rst)
    $rose(waiting) |-> (ticks_left == $past(timeout_ticks)))
    else $error("Timer not loaded on entering the wait state.");

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the stop-and-wait ARQ sender with a built-in predictor.
`timescale 1ns / 100ps

module tb_top;
  import swarq_pkg::*;

  localparam logic [1:0] REQ_UNKNOWN = 2'd3;
  localparam int DRAIN_CYCLES = 2 * PAYLOAD_BYTES + 8;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req_data = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [15:0] cfg_data = '0;

  stop_and_wait_arq_sender dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req_data(req_data),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp_data(rsp_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  // Predicted state of the sender.
  logic [15:0] timeout_val = TIMEOUT_RESET;
  bit          waiting = 1'b0;
  logic [31:0] next_seq = '0;
  logic [31:0] ack_due = '0;
  logic [15:0] ticks_left = '0;
  int          asm_pos = 0;
  logic [31:0] asm_sum = '0;
  bit          asm_blocked = 1'b0;
  logic [7:0]  payload_mem [QUEUE_DEPTH][PAYLOAD_BYTES];
  logic [31:0] seq_mem [QUEUE_DEPTH];
  logic [31:0] sum_mem [QUEUE_DEPTH];
  int          q_head = 0;
  int          q_tail = 0;
  int          q_count = 0;

  rsp_t pending_rsp[$];
  int   mismatches = 0;
  int   effective_count = 0;
  bit   gaps_on = 1'b1;
  int   long_stall = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

  task automatic expect_head_packet();
    rsp_t d;
    for (int i = 0; i < PAYLOAD_BYTES; i++) begin
      d.kind = KIND_PACKET;
      d.pkt_seq = seq_mem[q_head];
      d.pkt_checksum = sum_mem[q_head];
      d.pkt_byte = payload_mem[q_head][i];
      d.byte_pos = 5'(i);
      d.last = (i == PAYLOAD_BYTES - 1);
      pending_rsp.push_back(d);
    end
    waiting = 1'b1;
    ticks_left = timeout_val;
  endtask

  // Advances the predicted state by one accepted request and queues its results.
  task automatic track_request(input req_t r, output bit took_effect);
    rsp_t d;
    took_effect = 1'b0;
    case (r.req_type)
      REQ_MSG_BYTE: begin
        took_effect = 1'b1;
        if (asm_pos == 0) begin
          asm_blocked = (q_count >= QUEUE_DEPTH);
          asm_sum = '0;
        end
        if (!asm_blocked) payload_mem[q_tail][asm_pos] = r.msg_byte;
        asm_sum += r.msg_byte;
        asm_pos++;
        if (asm_pos == PAYLOAD_BYTES) begin
          asm_pos = 0;
          if (asm_blocked) begin
            asm_blocked = 1'b0;
            d = '0;
            d.kind = KIND_DROP;
            d.last = 1'b1;
            pending_rsp.push_back(d);
          end else begin
            seq_mem[q_tail] = next_seq;
            sum_mem[q_tail] = next_seq + DATA_ACK_FIELD + asm_sum;
            q_tail = (q_tail + 1) % QUEUE_DEPTH;
            q_count++;
            next_seq++;
            if (!waiting) expect_head_packet();
          end
        end
      end
      REQ_ACK: begin
        if (waiting && r.ack_checksum == r.ack_seq_field + r.ack_number &&
            r.ack_number == ack_due) begin
          took_effect = 1'b1;
          waiting = 1'b0;
          ack_due++;
          if (q_count > 0) begin
            q_head = (q_head + 1) % QUEUE_DEPTH;
            q_count--;
          end
          if (q_count > 0) expect_head_packet();
        end
      end
      REQ_TICK: begin
        if (waiting) begin
          took_effect = 1'b1;
          if (ticks_left > 1) ticks_left--;
          else if (q_count == 0) waiting = 1'b0;
          else expect_head_packet();
        end
      end
      default: took_effect = 1'b0;
    endcase
  endtask

  function automatic req_t random_req(logic [1:0] code);
    req_t r;
    r.req_type = code;
    r.msg_byte = 8'($urandom);
    r.ack_seq_field = $urandom;
    r.ack_number = $urandom;
    r.ack_checksum = $urandom;
    return r;
  endfunction

  function automatic req_t good_ack();
    req_t r;
    r = random_req(REQ_ACK);
    r.ack_number = ack_due;
    r.ack_checksum = r.ack_seq_field + r.ack_number;
    return r;
  endfunction

  function automatic req_t bad_ack();
    req_t r;
    logic [31:0] offs;
    r = good_ack();
    offs = $urandom_range(1, 5);
    if ($urandom_range(0, 1)) begin
      r.ack_checksum ^= 32'h1 << $urandom_range(0, 31);
    end else begin
      r.ack_number = $urandom_range(0, 1) ? ack_due + offs : ack_due - offs;
      r.ack_checksum = r.ack_seq_field + r.ack_number;
    end
    return r;
  endfunction

  function automatic req_t noise_req();
    case ($urandom_range(0, 3))
      0: return random_req(REQ_TICK);
      1: return random_req(REQ_ACK);
      2: return bad_ack();
      default: return random_req(REQ_UNKNOWN);
    endcase
  endfunction

  task automatic send_req(input req_t r);
    int gap;
    bit took;
    gap = gaps_on ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data <= r;
    do @(posedge clk); while (req_ready !== 1'b1);
    track_request(r, took);
    if (took) effective_count++;
  endtask

  task automatic send_message(input bit interleave);
    for (int i = 0; i < PAYLOAD_BYTES; i++) begin
      if (interleave && $urandom_range(0, 7) == 0) send_req(noise_req());
      send_req(random_req(REQ_MSG_BYTE));
    end
  endtask

  task automatic wait_quiet();
    req_valid <= 1'b0;
    while (pending_rsp.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_timeout(input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    timeout_val = value;
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Receiver side: random stalls, one long hold-off on demand, and the result check.
  initial begin
    int stall;
    rsp_t want;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (long_stall > 0) begin
        stall = long_stall;
        long_stall = 0;
      end else begin
        stall = gaps_on ? $urandom_range(0, 9) : 0;
      end
      if (stall > 0) begin
        rsp_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      do @(posedge clk); while (rsp_valid !== 1'b1);
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %h", $time, rsp_data);
        mismatches++;
      end else begin
        want = pending_rsp.pop_front();
        compare_field("kind", want.kind, rsp_data.kind);
        compare_field("pkt_seq", want.pkt_seq, rsp_data.pkt_seq);
        compare_field("pkt_checksum", want.pkt_checksum, rsp_data.pkt_checksum);
        compare_field("pkt_byte", want.pkt_byte, rsp_data.pkt_byte);
        compare_field("byte_pos", want.byte_pos, rsp_data.byte_pos);
        compare_field("last", want.last, rsp_data.last);
      end
    end
  end

  // An ACK, a tick and an unknown request on an idle sender must all be ignored.
  task automatic test_ignored_requests();
    req_t r;
    r = random_req(REQ_ACK);
    r.ack_seq_field = '0;
    r.ack_number = '0;
    r.ack_checksum = '0;
    send_req(r);
    send_req(random_req(REQ_TICK));
    r = '1;
    r.req_type = REQ_UNKNOWN;
    send_req(r);
    wait_quiet();
  endtask

  // One packet with extreme bytes, two bad ACKs, a timer resend and a wrapping checksum.
  task automatic test_timer_resend();
    req_t r;
    set_timeout(16'd1);
    for (int i = 0; i < PAYLOAD_BYTES; i++) begin
      r = random_req(REQ_MSG_BYTE);
      if (i < 8) r.msg_byte = i[0] ? 8'hFF : 8'h00;
      send_req(r);
    end
    r = good_ack();
    r.ack_checksum ^= 32'h8000_0000;
    send_req(r);
    r = good_ack();
    r.ack_number = ack_due + 1;
    r.ack_checksum = r.ack_seq_field + r.ack_number;
    send_req(r);
    send_req(random_req(REQ_TICK));
    r = good_ack();
    r.ack_seq_field = '1;
    r.ack_checksum = r.ack_seq_field + r.ack_number;
    send_req(r);
    wait_quiet();
  endtask

  // Fills the queue behind a long receiver hold-off until one message is dropped, then drains it.
  task automatic test_queue_full();
    set_timeout(16'hFFFF);
    long_stall = 300;
    repeat (QUEUE_DEPTH + 1) begin
      send_message(1'b0);
      send_req(random_req(REQ_TICK));
    end
    while (waiting) send_req(good_ack());
    wait_quiet();
  endtask

  task automatic test_random_traffic();
    int sel;
    logic [15:0] setting;
    for (int round = 0; round < 5; round++) begin
      case (round)
        0: setting = '0;
        1: setting = 16'd2;
        2: setting = 16'($urandom_range(3, 8));
        3: setting = 16'hFFFF;
        default: setting = TIMEOUT_RESET;
      endcase
      set_timeout(setting);
      effective_count = 0;
      while (effective_count < 20) begin
        gaps_on = ($urandom_range(0, 3) != 0);
        sel = $urandom_range(0, 99);
        if (sel < 40) send_message(1'($urandom_range(0, 1)));
        else if (sel < 65) send_req(waiting ? good_ack() : random_req(REQ_ACK));
        else if (sel < 80) repeat ($urandom_range(1, 4)) send_req(random_req(REQ_TICK));
        else send_req(noise_req());
      end
      gaps_on = 1'b1;
      wait_quiet();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_ignored_requests();
    test_timer_resend();
    test_queue_full();
    test_random_traffic();
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ stop_and_wait_arq_sender.f @@
hw/rtl/swarq_pkg.sv
hw/rtl/swarq_mem.sv
hw/rtl/stop_and_wait_arq_sender.sv
tb/sv/tb_top.sv
